FILE: src/lpg_pkg.sv
package lpg_pkg;

  // Screen geometry and frame buffer layout
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int ROW_SHIFT     = 10;  // 1024 bytes per row
  localparam int COL_SHIFT     = 1;   // 2 bytes per pixel

  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COORD_W = 9;   // major/minor coordinate width
  localparam int ERR_W   = 11;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 32;

  localparam logic [X_W-1:0] X_MAX = X_W'(SCREEN_WIDTH - 1);
  localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

  localparam logic [ADDR_W-1:0] PIXEL_BASE_RESET = 32'hC800_0000;

  // Command codes carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam int IN_FIELDS_W  = 2 * X_W + 2 * Y_W + COLOR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = X_W + Y_W + ADDR_W + COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Input tdata layout, first field in the low bits
  typedef struct packed {
    logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
    logic [COLOR_W-1:0]               stroke_color;
    logic [Y_W-1:0]                   stop_y;
    logic [X_W-1:0]                   stop_x;
    logic [Y_W-1:0]                   start_y;
    logic [X_W-1:0]                   start_x;
  } line_cmd_t;

  // Output tdata layout, first field in the low bits
  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
    logic [COLOR_W-1:0]                 pixel_color;
    logic [ADDR_W-1:0]                  pixel_address;
    logic [Y_W-1:0]                     pixel_y;
    logic [X_W-1:0]                     pixel_x;
  } pixel_t;

  // Rasterizer state for the line in progress
  typedef struct packed {
    logic                    steep;
    logic [COORD_W-1:0]      major_pos;
    logic [COORD_W-1:0]      major_end;
    logic [COORD_W-1:0]      minor_pos;
    logic                    minor_step_down;
    logic signed [ERR_W-1:0] err_term;
    logic [COORD_W-1:0]      major_delta;
    logic [COORD_W-1:0]      minor_delta;
    logic [COLOR_W-1:0]      held_color;
  } line_state_t;

endpackage

FILE: src/lpg_setup.sv
// Start command decode: clamp, octant select, endpoint ordering, error init.
module lpg_setup (
  input  lpg_pkg::line_cmd_t   cmd,
  output lpg_pkg::line_state_t init
);
  import lpg_pkg::*;

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] dx, dy;
  logic               steep;
  logic [COORD_W-1:0] p_maj, p_min, q_maj, q_min;
  logic [COORD_W-1:0] amaj, amin, bmaj, bmin;
  logic [COORD_W-1:0] maj_delta;
  logic [ERR_W-1:0]   half_delta;

  always_comb begin
    ax = (cmd.start_x > X_MAX) ? X_MAX : cmd.start_x;
    bx = (cmd.stop_x  > X_MAX) ? X_MAX : cmd.stop_x;
    ay = COORD_W'((cmd.start_y > Y_MAX) ? Y_MAX : cmd.start_y);
    by = COORD_W'((cmd.stop_y  > Y_MAX) ? Y_MAX : cmd.stop_y);

    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    steep = dy > dx;

    // swap axes for steep lines
    p_maj = steep ? ay : ax;
    p_min = steep ? ax : ay;
    q_maj = steep ? by : bx;
    q_min = steep ? bx : by;

    // major coordinate always rises
    if (p_maj > q_maj) begin
      amaj = q_maj; amin = q_min; bmaj = p_maj; bmin = p_min;
    end else begin
      amaj = p_maj; amin = p_min; bmaj = q_maj; bmin = q_min;
    end

    maj_delta  = bmaj - amaj;
    half_delta = ERR_W'(maj_delta >> 1);

    init.steep           = steep;
    init.major_pos       = amaj;
    init.major_end       = bmaj;
    init.minor_pos       = amin;
    init.minor_step_down = !(amin < bmin);
    init.err_term        = $signed(ERR_W'(0) - half_delta);
    init.major_delta     = maj_delta;
    init.minor_delta     = (amin > bmin) ? amin - bmin : bmin - amin;
    init.held_color      = cmd.stroke_color;
  end

endmodule

FILE: src/lpg_stepper.sv
// One Bresenham step: emit current pixel, advance error and coordinates.
module lpg_stepper (
  input  lpg_pkg::line_state_t     cur,
  input  logic [lpg_pkg::ADDR_W-1:0] pixel_base,
  output lpg_pkg::pixel_t          pix,
  output logic                     last,
  output lpg_pkg::line_state_t     nxt
);
  import lpg_pkg::*;

  logic [COORD_W-1:0]      px;
  logic [COORD_W-1:0]      py;
  logic [Y_W-1:0]          py_row;
  logic signed [ERR_W-1:0] err_add;
  logic                    minor_step;

  always_comb begin
    px     = cur.steep ? cur.minor_pos : cur.major_pos;
    py     = cur.steep ? cur.major_pos : cur.minor_pos;
    py_row = py[Y_W-1:0];
    last   = (cur.major_pos == cur.major_end);

    pix               = '0;
    pix.pixel_x       = px[X_W-1:0];
    pix.pixel_y       = py_row;
    pix.pixel_address = pixel_base + (ADDR_W'(py_row) << ROW_SHIFT)
                        + (ADDR_W'(px[X_W-1:0]) << COL_SHIFT);
    pix.pixel_color   = cur.held_color;

    err_add    = cur.err_term + $signed(ERR_W'(cur.minor_delta));
    minor_step = (cur.minor_delta != '0) && !err_add[ERR_W-1];

    nxt = cur;
    nxt.err_term = err_add;
    if (minor_step) begin
      nxt.err_term  = err_add - $signed(ERR_W'(cur.major_delta));
      nxt.minor_pos = cur.minor_step_down ? cur.minor_pos - 1'b1
                                          : cur.minor_pos + 1'b1;
    end
    if (!last) begin
      nxt.major_pos = cur.major_pos + 1'b1;
    end
  end

endmodule

FILE: src/line_pixel_generator_unit.sv
// Bresenham line rasterizer, one pixel per tick transaction while a line is drawing.
// A tick's pixel passes through the input register, then the result register,
//   before it is on m_axis.
// Throughput: one transaction per cycle, start or tick; only a stalled pixel holds the input.
// Reset (rst, synchronous, active high): both stages empty, no line drawing,
//   pixel_base back to 0xC8000000.
module line_pixel_generator_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: pixel_base
  input  logic                            cfg_wr_en,
  input  logic [lpg_pkg::ADDR_W-1:0]      cfg_wr_data,
  // command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, stop_x, stop_y, stroke_color, zero pad (low bit up)
  input  logic [lpg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd: 0 start, 1 tick
  input  logic                            s_axis_tuser,
  // pixel stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_x, pixel_y, pixel_address, pixel_color, zero pad (low bit up)
  output logic [lpg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast   // last_pixel
);
  import lpg_pkg::*;

  // Config register
  logic [ADDR_W-1:0] pixel_base;

  // Input stage
  logic      in_valid;
  logic      in_cmd;
  line_cmd_t in_line;

  // Rasterizer state
  logic        drawing;
  line_state_t line_st;

  // Result stage
  logic   out_valid;
  pixel_t out_pix;
  logic   out_last;

  // Combinational step results
  line_state_t setup_st;
  line_state_t step_st;
  pixel_t      step_pix;
  logic        step_last;

  logic emits;    // held transaction produces a pixel
  logic advance;  // held transaction is consumed this cycle

  lpg_setup u_setup (
    .cmd  (in_line),
    .init (setup_st)
  );

  lpg_stepper u_stepper (
    .cur        (line_st),
    .pixel_base (pixel_base),
    .pix        (step_pix),
    .last       (step_last),
    .nxt        (step_st)
  );

  // A start or an idle tick needs no room downstream.
  assign emits   = (in_cmd == CMD_TICK) && drawing;
  assign advance = in_valid && (!emits || !out_valid || m_axis_tready);

  // Input register takes a new transaction whenever it is empty or draining.
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pix;
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_base <= PIXEL_BASE_RESET;
    end else if (cfg_wr_en) begin
      pixel_base <= cfg_wr_data;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_line <= line_cmd_t'(s_axis_tdata);
    end
  end

  // Rasterizer state: start reloads, tick steps
  always_ff @(posedge clk) begin
    if (rst) begin
      drawing <= 1'b0;
    end else if (advance) begin
      if (in_cmd == CMD_START) begin
        drawing <= 1'b1;
      end else if (drawing && step_last) begin
        drawing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_cmd == CMD_START) begin
        line_st <= setup_st;
      end else if (drawing) begin
        line_st <= step_st;
      end
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emits) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emits) begin
      out_pix  <= step_pix;
      out_last <= step_last;
    end
  end

endmodule

FILE: src/lpg_checker.sv
module lpg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  // Nothing left in the result stage after reset.
  a_reset_out_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("pixel valid after reset");

  // Input stage is free after reset.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("command stream not ready after reset");

  // An empty result stage never backs up the command stream.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("command stream stalled with empty result stage");

  // A stalled pixel holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled pixel changed");

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
